/* hw/rtl/indexed_array_insert_erase_macros.svh */
// Assertion helpers shared by the RTL of the indexed array.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef INDEXED_ARRAY_INSERT_ERASE_MACROS_SVH
`define INDEXED_ARRAY_INSERT_ERASE_MACROS_SVH

// Plain property that must hold at every edge
`define IARR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle
`define IARR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/iarr_pkg.sv */
`default_nettype none

package iarr_pkg;

    // Array geometry
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 6;

    // Width used when comparing an index with the fill level
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [INDEX_W-1:0]       index;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } result_t;

    // One write port and one read port per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_PUT,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/iarr_mem.sv */
`default_nettype none

module iarr_mem (
    input  wire logic                            clk,
    input  wire iarr_pkg::mem_req_t              req,
    output logic [iarr_pkg::WORD_W-1:0]          rdata
);

    logic [iarr_pkg::WORD_W-1:0] entry_reg [iarr_pkg::CAPACITY];
    logic [iarr_pkg::WORD_W-1:0] rdata_reg;

    // Entry storage: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry_reg[req.waddr] <= req.wdata;
        end
        rdata_reg <= entry_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/iarr_seq.sv */
`default_nettype none

`include "indexed_array_insert_erase_macros.svh"

module iarr_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire iarr_pkg::cmd_t              cmd,
    output logic                             busy,
    output logic                             done,
    output iarr_pkg::result_t                result,
    output iarr_pkg::mem_req_t               mem_req,
    input  wire logic [iarr_pkg::WORD_W-1:0] rdata
);

    localparam int CNT_W  = iarr_pkg::CNT_W;
    localparam int ADDR_W = iarr_pkg::ADDR_W;
    localparam int CMP_W  = iarr_pkg::CMP_W;

    iarr_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [CNT_W-1:0]              ptr_reg, ptr_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [iarr_pkg::WORD_W-1:0]   value_reg, value_next;
    logic                          wpend_reg, wpend_next;
    logic [ADDR_W-1:0]             waddr_reg, waddr_next;
    logic                          done_reg, done_next;
    iarr_pkg::result_t             res_reg, res_next;

    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] ptr_dec;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] fill_ext;
    logic             refuse;

    // Pointer step unit
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign idx_ext  = CMP_W'(cmd.index);
    assign fill_ext = CMP_W'(fill_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iarr_pkg::ST_IDLE;
            fill_reg  <= '0;
            wpend_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wpend_reg <= wpend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        idx_reg   <= idx_next;
        value_reg <= value_next;
        waddr_reg <= waddr_next;
        res_reg   <= res_next;
    end

    // Sequencer: range checks, shift loops, final write, read and result
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        value_next = value_reg;
        wpend_next = wpend_reg;
        waddr_next = waddr_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        refuse     = 1'b0;
        mem_req    = '0;

        unique case (state_reg)
            iarr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    value_next = cmd.value;
                    idx_next   = CNT_W'(cmd.index);
                    wpend_next = 1'b0;
                    unique case (cmd.op)
                        iarr_pkg::OP_INSERT:
                        begin
                            if (fill_reg < CNT_W'(iarr_pkg::CAPACITY) && idx_ext <= fill_ext)
                            begin
                                ptr_next   = fill_reg;
                                state_next = iarr_pkg::ST_SHIFT_UP;
                            end
                            else
                            begin
                                refuse = 1'b1;
                            end
                        end
                        iarr_pkg::OP_ERASE:
                        begin
                            if (idx_ext < fill_ext)
                            begin
                                ptr_next   = CNT_W'(cmd.index);
                                state_next = iarr_pkg::ST_SHIFT_DN;
                            end
                            else
                            begin
                                refuse = 1'b1;
                            end
                        end
                        iarr_pkg::OP_READ:
                        begin
                            if (idx_ext < fill_ext)
                            begin
                                mem_req.raddr = ADDR_W'(cmd.index);
                                state_next    = iarr_pkg::ST_READ;
                            end
                            else
                            begin
                                refuse = 1'b1;
                            end
                        end
                        default:
                        begin
                            refuse = 1'b1;
                        end
                    endcase
                    if (refuse)
                    begin
                        done_next           = 1'b1;
                        res_next.ok         = 1'b0;
                        res_next.read_value = '0;
                        res_next.count      = iarr_pkg::COUNT_W'(fill_reg);
                    end
                end
            end

            // Move entries up, top first; read one ahead of the write
            iarr_pkg::ST_SHIFT_UP:
            begin
                if (wpend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = waddr_reg;
                    mem_req.wdata = rdata;
                end
                if (ptr_reg > idx_reg)
                begin
                    mem_req.raddr = ADDR_W'(ptr_dec);
                    wpend_next    = 1'b1;
                    waddr_next    = ADDR_W'(ptr_reg);
                    ptr_next      = ptr_dec;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        state_next = iarr_pkg::ST_PUT;
                    end
                end
            end

            // Move entries down, bottom first
            iarr_pkg::ST_SHIFT_DN:
            begin
                if (wpend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = waddr_reg;
                    mem_req.wdata = rdata;
                end
                if (ptr_inc < fill_reg)
                begin
                    mem_req.raddr = ADDR_W'(ptr_inc);
                    wpend_next    = 1'b1;
                    waddr_next    = ADDR_W'(ptr_reg);
                    ptr_next      = ptr_inc;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        fill_next           = fill_reg - CNT_W'(1);
                        done_next           = 1'b1;
                        res_next.ok         = 1'b1;
                        res_next.read_value = '0;
                        res_next.count      = iarr_pkg::COUNT_W'(fill_reg - CNT_W'(1));
                        state_next          = iarr_pkg::ST_IDLE;
                    end
                end
            end

            // Drop the new word into the opened slot
            iarr_pkg::ST_PUT:
            begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = ADDR_W'(idx_reg);
                mem_req.wdata       = value_reg;
                fill_next           = fill_reg + CNT_W'(1);
                done_next           = 1'b1;
                res_next.ok         = 1'b1;
                res_next.read_value = '0;
                res_next.count      = iarr_pkg::COUNT_W'(fill_reg + CNT_W'(1));
                state_next          = iarr_pkg::ST_IDLE;
            end

            // Registered read data is ready
            iarr_pkg::ST_READ:
            begin
                done_next           = 1'b1;
                res_next.ok         = 1'b1;
                res_next.read_value = rdata;
                res_next.count      = iarr_pkg::COUNT_W'(fill_reg);
                state_next          = iarr_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = iarr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != iarr_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Checks
    `IARR_ASSERT(a_fill_cap, fill_reg <= CNT_W'(iarr_pkg::CAPACITY), "fill above capacity")
    `IARR_ASSERT_IMPL(a_fill_on_done, fill_reg != $past(fill_reg), done_reg && res_reg.ok, "fill moved without a successful transfer")
    `IARR_ASSERT_IMPL(a_done_src, done_reg, $past(busy) || $past(start), "result with no command")
    `IARR_ASSERT_IMPL(a_wpend_shift, wpend_reg, state_reg == iarr_pkg::ST_SHIFT_UP || state_reg == iarr_pkg::ST_SHIFT_DN, "pending move outside shift")

endmodule

`default_nettype wire

/* hw/rtl/indexed_array_insert_erase.sv */
// Ordered list of up to 32 signed words with insert, erase and read at an
// index. A command is taken when start is high and busy is low; busy stays
// high until the command has finished. Each command gives exactly one result,
// shown for a single cycle with done high; the result cannot be held off, so
// the receiver must take it in that cycle. A refused command answers in the
// cycle after it is taken; a read answers once ST_READ has taken the
// registered read data. An insert or erase moves the n entries it displaces
// one per cycle through the entry memory (one read and one write a cycle).
// An erase then answers from ST_SHIFT_DN; an insert then writes the new word
// in ST_PUT and answers. The longest case is an insert at the front of a
// list holding CAPACITY - 1 words. A new command may be taken in the cycle
// its predecessor's result is shown.
`default_nettype none

module indexed_array_insert_erase (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire iarr_pkg::cmd_t     cmd,
    output logic                    busy,
    output logic                    done,
    output iarr_pkg::result_t       result
);

    iarr_pkg::mem_req_t          mem_req;
    logic [iarr_pkg::WORD_W-1:0] rdata;

    // Sequencer
    iarr_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // Entry memory
    iarr_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

/* dv/indexed_array_insert_erase_checker.sv */
`timescale 1ns / 1ps

// Watches the command and result channels, keeps a shadow copy of the list,
// and compares every result with the oldest outstanding prediction.
module indexed_array_insert_erase_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  iarr_pkg::cmd_t    cmd,
    input  wire logic         done,
    input  iarr_pkg::result_t result,
    output int                fail_count,
    output int                outstanding,
    output int                level,
    output int                results_seen,
    output int                full_hits
);

    import iarr_pkg::*;

    // Shadow list
    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len;

    // Predicted results, oldest first
    result_t expected_results [$];

    int mismatches;
    int seen;
    int fills;

    // Apply one command to the shadow list and return the result it gives
    function automatic result_t apply_cmd(input cmd_t c);
        result_t r;
        int      idx;
        r   = '0;
        idx = c.index;
        case (c.op)
            OP_INSERT:
            begin
                if (list_len < CAPACITY && idx <= list_len)
                begin
                    for (int i = list_len; i > idx; i--)
                        list_words[i] = list_words[i-1];
                    list_words[idx] = c.value;
                    list_len++;
                    r.ok = 1'b1;
                    if (list_len == CAPACITY)
                        fills++;
                end
            end
            OP_ERASE:
            begin
                if (idx < list_len)
                begin
                    for (int i = idx; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_READ:
            begin
                if (idx < list_len)
                begin
                    r.read_value = list_words[idx];
                    r.ok         = 1'b1;
                end
            end
            default:
            begin
                // unused code: refused, nothing changes
            end
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                list_words[i] = '0;
            list_len = 0;
            expected_results.delete();
            mismatches = 0;
            seen       = 0;
            fills      = 0;
            fail_count   <= 0;
            outstanding  <= 0;
            level        <= 0;
            results_seen <= 0;
            full_hits    <= 0;
        end
        else
        begin
            // Result transfer: compare against the oldest prediction
            if (done)
            begin
                seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing pending, got ok=%0b value=%h count=%0d",
                             $time, result.ok, result.read_value, result.count);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch, expected %0b, got %0b",
                                 $time, want.ok, result.ok);
                        mismatches++;
                    end
                    if (result.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch, expected %h, got %h",
                                 $time, want.read_value, result.read_value);
                        mismatches++;
                    end
                    if (result.count !== want.count)
                    begin
                        $display("%0t: count mismatch, expected %0d, got %0d",
                                 $time, want.count, result.count);
                        mismatches++;
                    end
                end
            end

            // Command transfer: predict its result
            if (start && !busy)
                expected_results.push_back(apply_cmd(cmd));

            fail_count   <= mismatches;
            outstanding  <= expected_results.size();
            level        <= list_len;
            results_seen <= seen;
            full_hits    <= fills;
        end
    end

endmodule

/* dv/indexed_array_insert_erase_tb.sv */
`timescale 1ns / 1ps

// Directed corner cases, then phases of random traffic that push the list
// to full and back to empty, with bursty command timing.
module indexed_array_insert_erase_tb;

    import iarr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET    = 550;
    localparam int MAX_GAP        = 40;
    localparam int DRAIN_CYCLES   = CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 500;

    typedef enum int {
        TRAFFIC_GROW,
        TRAFFIC_EVEN,
        TRAFFIC_SHRINK
    } traffic_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    cmd_t    cmd;
    result_t result;

    int fail_count;
    int outstanding;
    int level;
    int results_seen;
    int full_hits;

    int sent;
    int op_tally [4];
    int burst_left;
    bit idle_on;
    int idle_cycles;

    indexed_array_insert_erase dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    indexed_array_insert_erase_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .result       (result),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .level        (level),
        .results_seen (results_seen),
        .full_hits    (full_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Issue one command and wait for its transfer; idles between bursts when idle_on is set
    task automatic issue(input logic [OP_W-1:0] op, input int idx, input logic [WORD_W-1:0] val);
        cmd_t c;
        int   gap;
        if (burst_left <= 0)
        begin
            if (idle_on)
            begin
                gap = $urandom_range(1, MAX_GAP);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        c.op    = op;
        c.index = idx[INDEX_W-1:0];
        c.value = val;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
        sent++;
        op_tally[op]++;
    endtask

    // Mostly valid positions, some just past the end, some anywhere
    function automatic int pick_index(input int lim);
        int roll;
        if (lim < 0)
            lim = 0;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, lim);
        else if (roll < 92)
            return (lim + $urandom_range(1, 2) > 63) ? 63 : lim + $urandom_range(1, 2);
        else
            return $urandom_range(0, 63);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Stimulus
    initial
    begin
        traffic_t    mix;
        int          phase;
        int          phase_len;
        int          roll;
        logic [OP_W-1:0] op;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        sent       = 0;
        burst_left = 0;
        idle_on    = 1'b1;
        foreach (op_tally[i])
            op_tally[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list: everything but an insert at 0 is refused
        issue(OP_READ,   0,  32'h0);
        issue(OP_ERASE,  0,  32'h0);
        issue(OP_UNUSED, 0,  32'h1234_5678);
        issue(OP_INSERT, 1,  32'h0);
        issue(OP_INSERT, 63, 32'hffff_ffff);

        // Build a short list: front, end and middle inserts
        issue(OP_INSERT, 0, 32'h7fff_ffff);
        issue(OP_INSERT, 1, 32'h8000_0000);
        issue(OP_INSERT, 0, 32'hffff_ffff);
        issue(OP_INSERT, 1, 32'h0000_0000);
        issue(OP_INSERT, 2, 32'h5555_5555);
        issue(OP_INSERT, 5, 32'haaaa_aaaa);
        for (int i = 0; i < 6; i++)
            issue(OP_READ, i, 32'h0);

        // Out-of-range reads and erases
        issue(OP_READ,  6,  32'h0);
        issue(OP_READ,  63, 32'h0);
        issue(OP_ERASE, 6,  32'h0);

        // Erase at front, end and middle
        issue(OP_ERASE, 0, 32'h0);
        issue(OP_ERASE, 4, 32'h0);
        issue(OP_ERASE, 1, 32'h0);
        issue(OP_UNUSED, 63, 32'hdead_beef);
        issue(OP_READ,  0, 32'h0);

        // Random phases: grow to full, churn, shrink to empty, repeat
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            mix       = traffic_t'(phase % 3);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 70);
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                case (mix)
                    TRAFFIC_GROW:
                        op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_READ :
                             (roll < 97) ? OP_ERASE : OP_UNUSED;
                    TRAFFIC_SHRINK:
                        op = (roll < 15) ? OP_INSERT : (roll < 35) ? OP_READ :
                             (roll < 97) ? OP_ERASE : OP_UNUSED;
                    default:
                        op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_READ :
                             (roll < 97) ? OP_ERASE : OP_UNUSED;
                endcase
                issue(op, pick_index(op == OP_INSERT ? level : level - 1), pick_value());
            end
            phase++;
        end
        start <= 1'b0;

        // Drain and let any stray result show up
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d insert, %0d erase, %0d read, %0d unused op.",
                 sent, op_tally[OP_INSERT], op_tally[OP_ERASE], op_tally[OP_READ],
                 op_tally[OP_UNUSED]);
        $display("Checked %0d results; the list reached capacity %0d times.",
                 results_seen, full_hits);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/iarr_pkg.sv
hw/rtl/iarr_mem.sv
hw/rtl/iarr_seq.sv
hw/rtl/indexed_array_insert_erase.sv
dv/indexed_array_insert_erase_checker.sv
dv/indexed_array_insert_erase_tb.sv
